// File: design/pwrs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pwrs_pkg
// Shared types and constants for the weighted range sum block.
// ---------------------------------------------------------------------------
package pwrs_pkg;

  localparam int MaxN = 1048576;
  localparam int IdxW = $clog2(MaxN);
  localparam int CntW = IdxW + 1;
  localparam int ValW = 30;
  localparam logic [ValW-1:0] Modulus = 30'd1000000007;
  localparam logic [ValW-1:0] ExpInv = 30'd1000000005;
  localparam int ExpW = 30;
  // floor(2^60 / p) for the Barrett quotient estimate
  localparam logic [ValW:0] BarrettMu = 31'((64'd1 << 60) / 64'(Modulus));

  localparam logic [2:0] AddrBaseK = 3'd0;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RDWAIT,
    S_PW,
    S_LDMUL,
    S_QDIFF,
    S_EXP,
    S_QMUL,
    S_FIN,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// File: design/pwrs_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pwrs_ram
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module pwrs_ram #(
  parameter int Width = 30,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: design/pwrs_mulmod.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pwrs_mulmod
// Multi-cycle a*b mod p: a registered 30x30 multiply followed by a Barrett
// reduction; prod, qmu, qp and rem are registered in turn before done and y.
// ---------------------------------------------------------------------------
module pwrs_mulmod (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pwrs_pkg::ValW-1:0]  a,
  input  wire logic [pwrs_pkg::ValW-1:0]  b,
  output logic                            done,
  output logic      [pwrs_pkg::ValW-1:0]  y
);
  import pwrs_pkg::*;

  logic [2*ValW-1:0] prod;
  logic [2*ValW+1:0] qmu;
  logic [31:0]       qp;
  logic [31:0]       rem;
  logic [31:0]       rem1;
  logic [31:0]       rem2;
  logic [3:0]        stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done <= 1'b0;
    end else begin
      stage <= {stage[2:0], start};
      done <= stage[3];
    end
  end

  // quotient estimate is low by at most two, so the remainder is below 3p
  always_comb begin
    rem1 = (rem >= {2'b00, Modulus}) ? rem - {2'b00, Modulus} : rem;
    rem2 = (rem1 >= {2'b00, Modulus}) ? rem1 - {2'b00, Modulus} : rem1;
  end

  always_ff @(posedge clk) begin
    if (start) prod <= 60'(a) * 60'(b);
    if (stage[0]) qmu <= 62'(prod[2*ValW-1:ValW-1]) * 62'(BarrettMu);
    if (stage[1]) qp <= {1'b0, qmu[2*ValW+1:ValW+1]} * {2'b00, Modulus};
    if (stage[2]) rem <= prod[31:0] - qp;
    if (stage[3]) y <= rem2[ValW-1:0];
  end
endmodule
`default_nettype wire

// File: design/power_weighted_range_sum_mod_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// power_weighted_range_sum_mod_core
// Prefix memory of a_i*k^i mod p with weighted range queries.
// ---------------------------------------------------------------------------
// One input beat (s_tdata) gives one output beat (m_tdata). Opcode load
// appends an element and returns the new prefix, query returns the range sum
// scaled by the inverse of k^l, clear restarts loading at index one, the
// spare opcode does nothing. Items are worked one at a time through one
// shared mulmod (Barrett reduction). A load takes two mulmods and an in-range
// query 61 (the Fermat inverse by square-and-multiply plus the final
// product); a query whose power is zero takes none, and clear, no-op, a load
// into a full table or an out-of-range query go straight to the result beat.
// s_tready returns the cycle after the result beat, so a new item is taken
// only once the last result has been accepted.
// Two 2^20-entry RAMs hold prefix and power values; entries from loaded_count
// up are never used, so reset clears the count and running power. A result
// sits in the output register until m_tready; s_tready stays low meanwhile.
// The user writes base_k over APB at address 0 only between items, unenforced.
// ---------------------------------------------------------------------------
module power_weighted_range_sum_mod_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[1:0], element_value[32:2], left_index[53:33], right_index[74:54]
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result_value[29:0], status[31:30]
  output logic      [31:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import pwrs_pkg::*;

  state_t state, state_next;
  logic [ValW-1:0] base_k, running_power, kmod;
  logic [CntW-1:0] loaded_count;
  logic [1:0] op;
  logic [ValW-1:0] ev_mod, acc, sq, pw;
  logic [CntW-1:0] li, ri;
  logic [ExpW-1:0] expo;
  logic phase;       // exp: 0 multiply acc, 1 square
  logic [1:0] rd_step;
  logic [ValW-1:0] res;
  logic [1:0] st;
  logic mm_start, mm_done;
  logic [ValW-1:0] mm_a, mm_b, mm_y;
  logic p_we, w_we;
  logic [IdxW-1:0] p_addr, w_addr;
  logic [ValW-1:0] p_rd, w_rd, p_wd;
  logic [ValW-1:0] hi, lo;
  logic signed [30:0] ev;
  logic signed [31:0] ev_r;
  logic [ValW:0] sumv;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrBaseK[2]) ? {2'b00, base_k} : 32'd0;
  assign kmod = (base_k >= Modulus) ? base_k - Modulus : base_k;

  always_ff @(posedge clk) begin
    if (rst) base_k <= 30'd1;
    else if (psel && penable && pwrite && paddr[2] == AddrBaseK[2]) base_k <= pwdata[29:0];
  end

  // signed element into 0..p-1: |v| <= 2^30 < 2p
  assign ev = s_tdata[32:2];
  always_comb begin
    ev_r = 32'(ev);
    if (ev_r < 0) ev_r = ev_r + 32'sd1000000007;
    if (ev_r < 0) ev_r = ev_r + 32'sd1000000007;
    if (ev_r >= 32'sd1000000007) ev_r = ev_r - 32'sd1000000007;
  end

  pwrs_mulmod u_mm (.clk, .rst, .start(mm_start), .a(mm_a), .b(mm_b),
                    .done(mm_done), .y(mm_y));
  pwrs_ram #(.Width(ValW), .Depth(MaxN)) u_pref (.clk, .we(p_we), .addr(p_addr),
                                                .wdata(p_wd), .rdata(p_rd));
  pwrs_ram #(.Width(ValW), .Depth(MaxN)) u_pow (.clk, .we(w_we), .addr(w_addr),
                                               .wdata(pw), .rdata(w_rd));

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {st, res};
  assign sumv = {1'b0, hi} + {1'b0, mm_y};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) begin
        case (s_tdata[1:0])
          OpLoad: state_next = (loaded_count == CntW'(MaxN)) ? S_OUT : S_RD;
          OpQuery: begin
            if (s_tdata[53:33] == '0 || s_tdata[74:54] == '0 ||
                s_tdata[53:33] > loaded_count || s_tdata[74:54] > loaded_count)
              state_next = S_OUT;
            else state_next = S_RD;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_RD: state_next = S_RDWAIT;
      S_RDWAIT: if (rd_step == 2'd2) state_next = (op == OpLoad) ? S_PW : S_QDIFF;
      S_PW: if (mm_done) state_next = S_LDMUL;
      S_LDMUL: if (mm_done) state_next = S_FIN;
      S_QDIFF: state_next = (pw == '0) ? S_FIN : S_EXP;
      S_EXP: if (mm_done && phase && expo[ExpW-1:1] == '0) state_next = S_QMUL;
      S_QMUL: if (mm_done) state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory addressing and mulmod operands
  always_comb begin
    p_we = 1'b0;
    w_we = 1'b0;
    p_wd = sumv >= {1'b0, Modulus} ? 30'(sumv - {1'b0, Modulus}) : sumv[ValW-1:0];
    p_addr = IdxW'(loaded_count);
    w_addr = IdxW'(loaded_count);
    mm_start = 1'b0;
    mm_a = '0;
    mm_b = '0;
    case (state)
      S_RD, S_RDWAIT: begin
        if (op == OpLoad) begin
          p_addr = IdxW'(loaded_count - CntW'(1));
        end else if (rd_step == 2'd0) begin
          p_addr = IdxW'(ri - CntW'(1));
          w_addr = IdxW'(li - CntW'(1));
        end else begin
          p_addr = IdxW'(li - CntW'(2));
        end
      end
      S_FIN: if (op == OpLoad) begin
        p_we = 1'b1;
        w_we = 1'b1;
      end
      default: ;
    endcase
    if (state == S_RDWAIT && rd_step == 2'd2 && op == OpLoad) begin
      mm_start = 1'b1;
      mm_a = running_power;
      mm_b = kmod;
    end
    if (state == S_PW && mm_done) begin
      mm_start = 1'b1;
      mm_a = ev_mod;
      mm_b = mm_y;
    end
    // first multiply of the exponent loop, acc starts at one
    if (state == S_QDIFF && pw != '0) begin
      mm_start = 1'b1;
      mm_a = 30'd1;
      mm_b = ExpInv[0] ? pw : 30'd1;
    end
    if (state == S_EXP && mm_done) begin
      mm_start = 1'b1;
      if (!phase) begin
        mm_a = sq;
        mm_b = sq;
      end else if (expo[ExpW-1:1] != '0) begin
        mm_a = acc;
        mm_b = expo[1] ? mm_y : 30'd1;
      end else begin
        // exponent used up: scale the difference by the inverse
        mm_a = hi;
        mm_b = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      loaded_count <= '0;
      running_power <= 30'd1;
    end else begin
      state <= state_next;
      if (state == S_IDLE && s_tvalid && s_tdata[1:0] == OpClear) begin
        loaded_count <= '0;
        running_power <= 30'd1;
      end
      if (state == S_FIN && op == OpLoad) begin
        loaded_count <= loaded_count + CntW'(1);
        running_power <= pw;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op <= s_tdata[1:0];
        ev_mod <= ev_r[ValW-1:0];
        li <= s_tdata[53:33];
        ri <= s_tdata[74:54];
        rd_step <= 2'd0;
        res <= '0;
        st <= StOk;
        if (s_tdata[1:0] == OpLoad && loaded_count == CntW'(MaxN)) st <= StFull;
        if (s_tdata[1:0] == OpQuery && (s_tdata[53:33] == '0 || s_tdata[74:54] == '0 ||
            s_tdata[53:33] > loaded_count || s_tdata[74:54] > loaded_count)) st <= StRange;
      end
      S_RDWAIT: begin
        rd_step <= rd_step + 2'd1;
        if (rd_step == 2'd0) begin
          hi <= (op == OpLoad && loaded_count == '0) ? '0 : p_rd;
          pw <= w_rd;
        end
        if (rd_step == 2'd2 && op != OpLoad) lo <= (li == CntW'(1)) ? '0 : p_rd;
      end
      S_PW: if (mm_done) pw <= mm_y;
      S_QDIFF: begin
        hi <= (hi >= lo) ? hi - lo : 30'(31'(hi) + 31'(Modulus) - 31'(lo));
        sq <= pw;
        acc <= 30'd1;
        expo <= ExpInv;
        phase <= 1'b0;
      end
      S_EXP: if (mm_done) begin
        if (!phase) begin
          acc <= mm_y;
          phase <= 1'b1;
        end else begin
          sq <= mm_y;
          expo <= expo >> 1;
          phase <= 1'b0;
        end
      end
      S_FIN: begin
        if (op == OpLoad) res <= p_wd;
        else if (pw != '0) res <= mm_y;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst) loaded_count <= CntW'(MaxN))
    else $error("count past capacity");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
